/* design/pds_pkg.sv */
// shared constants for the audio pll divider search
// no dependencies
package pds_pkg;

    // vco window in hz, scaled by 65536
    localparam logic [45:0] VCO_MIN_S = 46'd22937600000000;
    localparam logic [45:0] VCO_MAX_S = 46'd32768000000000;

    // width of the post divisor 2*code+4
    localparam int unsigned DIV_W = 7;

    // dividend width of the final serial divisions
    localparam int unsigned QNUM_W = 35;

endpackage

/* design/pds_sdiv.sv */
// bit-serial restoring divider by a small divisor, one quotient bit per step
// depends on pds_pkg
module pds_sdiv #(
    parameter int unsigned NUM_W = 35
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [pds_pkg::DIV_W-1:0]    i_den,
    output logic [NUM_W-1:0]             o_quot
);

    logic [NUM_W-1:0]          r_num;
    logic [pds_pkg::DIV_W-1:0] r_rem;
    logic [pds_pkg::DIV_W:0]   w_trial;
    logic                      w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (i_step) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? pds_pkg::DIV_W'(w_trial - {1'b0, i_den})
                          : w_trial[pds_pkg::DIV_W-1:0];
        end
    end

    assign o_quot = r_num;

endmodule

/* design/pll_divider_search.sv */
// audio pll divider search top level
// depends on pds_pkg and pds_sdiv
//
// one target frequency in, one pll setting out. the block walks post divider
// codes 0..POST_DIV_MAX (outer) and integer parts 4..8 (inner). a candidate
// whose vco misses the window takes one step to form
// t = 2*f*div - xtal*(4+int), a restoring division of t by the crystal
// giving both fractional words, one clamp step, a shift-add multiply for
// the scaled vco, one evaluation step and a step to the next candidate.
// the first in-window candidate adds a take step. a later one adds a cross
// multiply against the best error so far and a decision step, and the take
// step when it is better. with the default 31 the search runs 160
// candidates. it is followed by a serial division for the achieved
// frequency and error and a load of the output register, which waits
// while a previous result is still stalled there. one item is taken at a
// time; the next target is taken once the result has been loaded into the
// output register, while it may still wait there. the user must write
// xtal_hz through i_cfg_we/i_cfg_data only while the block is idle; the
// block itself does not enforce this.
module pll_divider_search #(
    parameter int unsigned POST_DIV_MAX = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [25:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [26:0] i_target_freq_hz,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [7:0]  o_frac_low,
    output logic [7:0]  o_frac_high,
    output logic [3:0]  o_int_part,
    output logic [4:0]  o_post_div,
    output logic [25:0] o_achieved_freq_hz,
    output logic signed [27:0] o_freq_error_hz
);

    localparam int unsigned DW = pds_pkg::DIV_W;
    localparam int unsigned QW = pds_pkg::QNUM_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_T     = 12'b000000000010,
        S_DIV   = 12'b000000000100,
        S_CLAMP = 12'b000000001000,
        S_MUL   = 12'b000000010000,
        S_EVAL  = 12'b000000100000,
        S_CMP   = 12'b000001000000,
        S_DEC   = 12'b000010000000,
        S_TAKE  = 12'b000100000000,
        S_NEXT  = 12'b001000000000,
        S_FDIV  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state;

    logic [25:0] r_xtal;
    logic [26:0] r_f;
    logic [4:0]  r_pd;
    logic [3:0]  r_ip;
    logic [DW-1:0] r_div;
    logic [34:0] r_a;       // 2*f*div
    logic [29:0] r_b;       // xtal*(4+int)
    logic        r_neg;
    logic        r_sat;
    logic [25:0] r_rem;
    logic [15:0] r_q;
    logic [7:0]  r_s1;
    logic [7:0]  r_s0;
    logic [45:0] r_v;
    logic [41:0] r_xs;
    logic [15:0] r_mq;
    logic [51:0] r_ae;
    logic        r_sneg;
    logic [58:0] r_p1;
    logic [58:0] r_p2;
    logic [58:0] r_e1;
    logic [58:0] r_e2;
    logic [DW-1:0] r_m1;
    logic [DW-1:0] r_m2;
    logic [5:0]  r_cnt;
    logic        r_have;

    // best setting so far
    logic [51:0] r_best_err;
    logic [DW-1:0] r_best_div;
    logic [45:0] r_best_v;
    logic        r_best_sneg;
    logic [7:0]  r_best_s0;
    logic [7:0]  r_best_s1;
    logic [3:0]  r_best_ip;
    logic [4:0]  r_best_pd;

    // output register
    logic        r_o_valid;
    logic        r_o_found;
    logic [7:0]  r_o_lo;
    logic [7:0]  r_o_hi;
    logic [3:0]  r_o_ip;
    logic [4:0]  r_o_pd;
    logic [25:0] r_o_ach;
    logic [27:0] r_o_err;

    logic        w_in_xfer;
    logic        w_out_xfer;
    logic signed [36:0] w_t;
    logic        w_t_ge_x;
    logic [26:0] w_trial;
    logic        w_ge;
    logic [7:0]  w_lo_lim;
    logic        w_ip8;
    logic [7:0]  n_s1;
    logic [7:0]  n_s0;
    logic signed [52:0] w_sig;
    logic [51:0] w_ae;
    logic        w_in_win;
    logic        w_last_cand;
    logic        w_load_div;
    logic        w_step_div;
    logic [QW-1:0] w_q_ach;
    logic [QW-1:0] w_q_err;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_o_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // t = 2*f*div - xtal*(4+int), sign and integer part of t/xtal
    assign w_t      = $signed({2'b0, r_a}) - $signed({7'b0, r_b});
    assign w_t_ge_x = (w_t[35:0] >= {10'b0, r_xtal});

    // restoring division step of t by the crystal
    assign w_trial = {r_rem, 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_xtal});

    // clamp of the fractional words
    assign w_ip8    = (r_ip == 4'd8);
    assign w_lo_lim = (r_ip == 4'd4) ? 8'd192 : 8'd0;

    always_comb begin
        n_s1 = r_q[15:8];
        n_s0 = r_q[7:0];
        if (r_neg) begin
            n_s1 = w_lo_lim;
            n_s0 = 8'd0;
        end else if (r_sat) begin
            n_s1 = w_ip8 ? 8'd128 : 8'd255;
            n_s0 = w_ip8 ? 8'd0 : 8'd255;
        end else if (r_q[15:8] < w_lo_lim) begin
            n_s1 = w_lo_lim;
            n_s0 = 8'd0;
        end else if (w_ip8 && r_q[15:8] >= 8'd128) begin
            // top integer part stops at half with the low word cleared
            n_s1 = 8'd128;
            n_s0 = 8'd0;
        end
    end

    // signed error scaled by 2^17*div, and the vco window
    assign w_sig    = $signed({2'b0, r_a, 16'b0}) - $signed({7'b0, r_v});
    assign w_ae     = w_sig[52] ? 52'(53'sd0 - w_sig) : w_sig[51:0];
    assign w_in_win = (r_v >= pds_pkg::VCO_MIN_S) && (r_v <= pds_pkg::VCO_MAX_S);

    assign w_last_cand = w_ip8 && (r_pd == 5'(POST_DIV_MAX));
    assign w_load_div  = (r_state == S_NEXT) && w_last_cand;
    assign w_step_div  = (r_state == S_FDIV);

    // achieved frequency: floor((v >> 17) / div)
    pds_sdiv #(.NUM_W(QW)) u_div_ach (
        .i_clk  (i_clk),
        .i_load (w_load_div),
        .i_step (w_step_div),
        .i_num  ({6'b0, r_best_v[45:17]}),
        .i_den  (r_best_div),
        .o_quot (w_q_ach)
    );

    // error magnitude: floor((|err| >> 17) / div)
    pds_sdiv #(.NUM_W(QW)) u_div_err (
        .i_clk  (i_clk),
        .i_load (w_load_div),
        .i_step (w_step_div),
        .i_num  (r_best_err[51:17]),
        .i_den  (r_best_div),
        .o_quot (w_q_err)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal <= 26'd40000000;
        end else if (i_cfg_we) begin
            r_xtal <= i_cfg_data;
        end
    end

    // search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_f     <= i_target_freq_hz;
                        r_pd    <= '0;
                        r_ip    <= 4'd4;
                        r_div   <= DW'(4);
                        r_a     <= {5'b0, i_target_freq_hz, 3'b0};
                        r_b     <= {1'b0, r_xtal, 3'b0};
                        r_have  <= 1'b0;
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    r_neg   <= w_t[36];
                    r_sat   <= !w_t[36] && w_t_ge_x;
                    r_rem   <= w_t[25:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? 26'(w_trial - {1'b0, r_xtal}) : w_trial[25:0];
                    r_q   <= {r_q[14:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_s1    <= n_s1;
                    r_s0    <= n_s0;
                    r_v     <= {r_b, 16'b0};
                    r_xs    <= {16'b0, r_xtal};
                    r_mq    <= {n_s1, n_s0};
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mq[0]) begin
                        r_v <= r_v + {4'b0, r_xs};
                    end
                    r_xs  <= {r_xs[40:0], 1'b0};
                    r_mq  <= {1'b0, r_mq[15:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_ae   <= w_ae;
                    r_sneg <= w_sig[52];
                    r_p1   <= '0;
                    r_p2   <= '0;
                    r_e1   <= {7'b0, w_ae};
                    r_e2   <= {7'b0, r_best_err};
                    r_m1   <= r_best_div;
                    r_m2   <= r_div;
                    r_cnt  <= '0;
                    if (!w_in_win) begin
                        r_state <= S_NEXT;
                    end else if (!r_have) begin
                        r_state <= S_TAKE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // ae*best_div against best_err*div, one multiplier bit a cycle
                    if (r_m1[0]) begin
                        r_p1 <= r_p1 + r_e1;
                    end
                    if (r_m2[0]) begin
                        r_p2 <= r_p2 + r_e2;
                    end
                    r_e1  <= {r_e1[57:0], 1'b0};
                    r_e2  <= {r_e2[57:0], 1'b0};
                    r_m1  <= {1'b0, r_m1[DW-1:1]};
                    r_m2  <= {1'b0, r_m2[DW-1:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DW - 1)) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    // strictly smaller only, so the earliest of equal errors stays
                    r_state <= (r_p1 < r_p2) ? S_TAKE : S_NEXT;
                end
                S_TAKE: begin
                    r_have      <= 1'b1;
                    r_best_err  <= r_ae;
                    r_best_div  <= r_div;
                    r_best_v    <= r_v;
                    r_best_sneg <= r_sneg;
                    r_best_s0   <= r_s0;
                    r_best_s1   <= r_s1;
                    r_best_ip   <= r_ip;
                    r_best_pd   <= r_pd;
                    r_state     <= S_NEXT;
                end
                S_NEXT: begin
                    r_cnt <= '0;
                    if (w_last_cand) begin
                        r_state <= S_FDIV;
                    end else if (w_ip8) begin
                        r_pd    <= r_pd + 5'd1;
                        r_div   <= r_div + DW'(2);
                        r_a     <= r_a + {6'b0, r_f, 2'b0};
                        r_ip    <= 4'd4;
                        r_b     <= {1'b0, r_xtal, 3'b0};
                        r_state <= S_T;
                    end else begin
                        r_ip    <= r_ip + 4'd1;
                        r_b     <= r_b + {4'b0, r_xtal};
                        r_state <= S_T;
                    end
                end
                S_FDIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(QW - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait until the output register is free
                    if (!r_o_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register, a nothing-found result is all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_o_valid || !i_out_stall)) begin
            r_o_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_o_valid || !i_out_stall)) begin
            r_o_found <= r_have;
            r_o_lo    <= r_have ? r_best_s0 : 8'd0;
            r_o_hi    <= r_have ? r_best_s1 : 8'd0;
            r_o_ip    <= r_have ? r_best_ip : 4'd0;
            r_o_pd    <= r_have ? r_best_pd : 5'd0;
            r_o_ach   <= r_have ? w_q_ach[25:0] : 26'd0;
            r_o_err   <= !r_have ? 28'd0
                       : r_best_sneg ? 28'(QW'(0) - w_q_err) : w_q_err[27:0];
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_found            = r_o_found;
    assign o_frac_low         = r_o_lo;
    assign o_frac_high        = r_o_hi;
    assign o_int_part         = r_o_ip;
    assign o_post_div         = r_o_pd;
    assign o_achieved_freq_hz = r_o_ach;
    assign o_freq_error_hz    = $signed(r_o_err);

`ifndef SYNTH
    // a kept setting always lies inside the vco window
    a_best_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_best_v >= pds_pkg::VCO_MIN_S && r_best_v <= pds_pkg::VCO_MAX_S))
        else $error("kept setting outside vco window");

    // a found result carries an integer part of 4..8
    a_found_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_int_part >= 4'd4 && o_int_part <= 4'd8))
        else $error("found result with bad integer part");

    // nothing found gives an all-zero result
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_frac_low == 8'd0 && o_frac_high == 8'd0 &&
        o_int_part == 4'd0 && o_post_div == 5'd0 && o_achieved_freq_hz == 26'd0 &&
        o_freq_error_hz == 28'sd0))
        else $error("empty result not zero");

    // an accepted target starts a fresh search
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_T && !r_have && r_pd == 5'd0 && r_ip == 4'd4))
        else $error("search did not start cleanly");
`endif

endmodule
